FILE: src/ist_pkg.sv
// Shared types and constants for the integer set table.
// Depends on nothing; every other file of the block imports it.
package ist_pkg;

  localparam int unsigned IST_CAPACITY = 64;

  localparam int unsigned IST_OP_W     = 3;
  localparam int unsigned IST_KEY_W    = 32;
  localparam int unsigned IST_STATUS_W = 2;
  localparam int unsigned IST_COUNT_W  = 7;

  typedef enum logic [IST_OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_QUERY  = 3'd1,
    OP_REMOVE = 3'd2,
    OP_BEGIN  = 3'd3,
    OP_TAKE   = 3'd4
  } ist_op_e;

  typedef enum logic [IST_STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_END       = 2'd3
  } ist_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RD_LAST,
    S_MOVE,
    S_TAKE_RD,
    S_TAKE_DATA,
    S_RESP
  } ist_state_e;

  // Control strobes from the sequencer to the entry memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ist_mem_ctl_t;

endpackage

FILE: src/ist_in_if.sv
// Request channel of the integer set table: valid/ready plus opcode and key.
// Depends on ist_pkg for the field widths.
interface ist_in_if
  import ist_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [IST_OP_W-1:0]         opcode;
  logic signed [IST_KEY_W-1:0] key;

  modport source (output valid, output opcode, output key, input ready);
  modport sink   (input valid, input opcode, input key, output ready);
endinterface

FILE: src/ist_out_if.sv
// Response channel of the integer set table: valid/ready plus status, item and count.
// Depends on ist_pkg for the field widths.
interface ist_out_if
  import ist_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic [IST_STATUS_W-1:0]     status;
  logic signed [IST_KEY_W-1:0] item;
  logic [IST_COUNT_W-1:0]      count;

  modport source (output valid, output status, output item, output count, input ready);
  modport sink   (input valid, input status, input item, input count, output ready);
endinterface

FILE: src/integer_set_table.sv
// Integer set table: a set of up to CAPACITY distinct 32-bit signed keys held densely in
// a single-port-per-direction memory, one request at a time. Insert, query and remove scan
// the stored entries with one memory read per cycle; on a hit, remove then reads the last
// entry and moves it into the hole. Iterator take reads the entry at the iterator position
// or reports the end, and iterator begin resets the iterator. The scan rate is set by the
// one read port of the entry memory. No clearing pass follows reset: only entries below
// the count are ever read. The response sits in an output register, and a count above 127
// is reported modulo 128.
module integer_set_table
  import ist_pkg::*;
#(
  parameter int unsigned CAPACITY = IST_CAPACITY
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ist_in_if.sink    in_i,
  ist_out_if.source out_o
);

  localparam int unsigned AW = $clog2(CAPACITY);

  ist_mem_ctl_t         mem_ctl;
  logic [AW-1:0]        rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [IST_KEY_W-1:0] wr_data;
  logic [IST_KEY_W-1:0] rd_data;

  ist_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .out_o     (out_o),
    .mem_ctl_o (mem_ctl),
    .rd_addr_o (rd_addr),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .rd_data_i (rd_data)
  );

  ist_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

endmodule

FILE: src/ist_mem.sv
// Entry store of the integer set table: one write port, one read port, registered read data.
// Depends on ist_pkg for the control struct and key width.
module ist_mem
  import ist_pkg::*;
#(
  parameter int unsigned CAPACITY = IST_CAPACITY,
  localparam int unsigned AW = $clog2(CAPACITY)
) (
  input  logic                 clk_i,
  input  ist_mem_ctl_t         ctl_i,
  input  logic [AW-1:0]        rd_addr_i,
  input  logic [AW-1:0]        wr_addr_i,
  input  logic [IST_KEY_W-1:0] wr_data_i,
  output logic [IST_KEY_W-1:0] rd_data_o
);

  logic [IST_KEY_W-1:0] mem_q [CAPACITY];
  logic [IST_KEY_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/ist_ctrl.sv
// Sequencer of the integer set table: linear scan, insert, remove, iterator and
// the response register. Depends on ist_pkg and the two channel interfaces.
module ist_ctrl
  import ist_pkg::*;
#(
  parameter int unsigned CAPACITY = IST_CAPACITY,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ist_in_if.sink               in_i,
  ist_out_if.source            out_o,
  output ist_mem_ctl_t         mem_ctl_o,
  output logic [AW-1:0]        rd_addr_o,
  output logic [AW-1:0]        wr_addr_o,
  output logic [IST_KEY_W-1:0] wr_data_o,
  input  logic [IST_KEY_W-1:0] rd_data_i
);

  ist_state_e state_q, state_d;

  logic [IST_OP_W-1:0]      op_q;
  logic [IST_KEY_W-1:0]     key_q;
  logic [CW-1:0]            count_q;
  logic [CW-1:0]            idx_q;
  logic [CW-1:0]            cmp_idx_q;
  logic                     cmp_valid_q;
  logic [CW-1:0]            pos_q;
  logic [CW-1:0]            iter_pos_q;
  logic                     iter_valid_q;
  logic [IST_STATUS_W-1:0]  res_status_q;
  logic [IST_KEY_W-1:0]     res_item_q;

  logic                     out_valid_q;
  logic [IST_STATUS_W-1:0]  out_status_q;
  logic [IST_KEY_W-1:0]     out_item_q;
  logic [IST_COUNT_W-1:0]   out_count_q;

  logic                     in_fire;
  logic                     hit;
  logic                     more;
  logic                     can_take;
  logic                     resp_load;
  logic [CW-1:0]            last_idx;
  logic [CW+IST_COUNT_W-1:0] count_ext;

  assign in_fire   = in_i.valid && in_i.ready;
  // The compare stage checks the read data registered from the address of the cycle before.
  assign hit       = cmp_valid_q && (rd_data_i == key_q);
  assign more      = idx_q < count_q;
  assign can_take  = iter_valid_q && (iter_pos_q < count_q);
  assign resp_load = (state_q == S_RESP) && (!out_valid_q || out_o.ready);
  assign last_idx  = count_q - CW'(1);
  assign count_ext = {{IST_COUNT_W{1'b0}}, count_q};

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          priority case (in_i.opcode)
            OP_INSERT, OP_QUERY, OP_REMOVE: state_d = S_SCAN;
            OP_TAKE:                        state_d = S_TAKE_RD;
            default:                        state_d = S_RESP;
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          state_d = (op_q == OP_REMOVE) ? S_RD_LAST : S_RESP;
        end else if (!more) begin
          state_d = S_RESP;
        end
      end
      S_RD_LAST:   state_d = S_MOVE;
      S_MOVE:      state_d = S_RESP;
      S_TAKE_RD:   state_d = can_take ? S_TAKE_DATA : S_RESP;
      S_TAKE_DATA: state_d = S_RESP;
      S_RESP: begin
        if (resp_load) begin
          state_d = S_IDLE;
        end
      end
      default:     state_d = S_IDLE;
    endcase
  end

  // Memory strobes and handshake outputs.
  always_comb begin
    mem_ctl_o = '0;
    rd_addr_o = idx_q[AW-1:0];
    wr_addr_o = count_q[AW-1:0];
    wr_data_o = key_q;
    in_i.ready = (state_q == S_IDLE);
    unique case (state_q)
      S_SCAN: begin
        if (!hit && more) begin
          mem_ctl_o.rd_en = 1'b1;
        end else if (!hit && (op_q == OP_INSERT) && (count_q < CW'(CAPACITY))) begin
          mem_ctl_o.wr_en = 1'b1;
        end
      end
      S_RD_LAST: begin
        mem_ctl_o.rd_en = 1'b1;
        rd_addr_o       = last_idx[AW-1:0];
      end
      S_MOVE: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = pos_q[AW-1:0];
        wr_data_o       = rd_data_i;
      end
      S_TAKE_RD: begin
        mem_ctl_o.rd_en = can_take;
        rd_addr_o       = iter_pos_q[AW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      iter_pos_q   <= '0;
      iter_valid_q <= 1'b0;
      cmp_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        cmp_valid_q <= 1'b0;
        if (in_i.opcode == OP_BEGIN) begin
          iter_pos_q   <= '0;
          iter_valid_q <= 1'b1;
        end
      end
      if (state_q == S_SCAN) begin
        cmp_valid_q <= !hit && more;
        if (mem_ctl_o.wr_en) begin
          count_q <= count_q + CW'(1);
        end
      end
      if (state_q == S_MOVE) begin
        count_q <= last_idx;
      end
      if (state_q == S_TAKE_DATA) begin
        iter_pos_q <= iter_pos_q + CW'(1);
      end
      if (resp_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q         <= in_i.opcode;
      key_q        <= in_i.key;
      idx_q        <= '0;
      res_status_q <= ST_OK;
      res_item_q   <= '0;
    end
    if (state_q == S_SCAN) begin
      if (hit) begin
        pos_q <= cmp_idx_q;
      end else if (more) begin
        idx_q     <= idx_q + CW'(1);
        cmp_idx_q <= idx_q;
      end else if (op_q == OP_INSERT) begin
        if (count_q >= CW'(CAPACITY)) begin
          res_status_q <= ST_FULL;
        end
      end else begin
        res_status_q <= ST_NOT_FOUND;
      end
    end
    if ((state_q == S_TAKE_RD) && !can_take) begin
      res_status_q <= ST_END;
    end
    if (state_q == S_TAKE_DATA) begin
      res_item_q <= rd_data_i;
    end
    if (resp_load) begin
      out_status_q <= res_status_q;
      out_item_q   <= res_item_q;
      out_count_q  <= count_ext[IST_COUNT_W-1:0];
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.status = out_status_q;
  assign out_o.item   = out_item_q;
  assign out_o.count  = out_count_q;

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_read_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl_o.rd_en |-> (CW'(rd_addr_o) < count_q))
    else $error("read of an entry at or above the count");

  a_one_port_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl_o.rd_en && mem_ctl_o.wr_en))
    else $error("read and write issued in the same cycle");

  a_count_needs_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(mem_ctl_o.wr_en))
    else $error("count changed without a memory write");

  a_accept_leaves_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after a request transaction");

endmodule

FILE: tb/sv/tb_integer_set_table.sv
`timescale 1ns / 100ps
// Self-checking testbench for the integer set table: drives requests, predicts every response.
// Depends on ist_pkg, the ist_in_if and ist_out_if interfaces and the integer_set_table module.
module tb_integer_set_table;
  import ist_pkg::*;

  localparam int unsigned ITEMS_TARGET = 1450;
  localparam int unsigned POOL_SIZE    = 96;
  localparam int unsigned REPORT_LIMIT = 100;

  localparam logic signed [IST_KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [IST_KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    ist_status_e                 status;
    logic signed [IST_KEY_W-1:0] item;
    logic [IST_COUNT_W-1:0]      count;
  } set_response_t;

  typedef enum int {
    SINK_FREE,
    SINK_RANDOM,
    SINK_STALLS
  } sink_mode_e;

  logic clk_i;
  logic rst_ni;

  ist_in_if  req_if ();
  ist_out_if rsp_if ();

  integer_set_table i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  // Shadow copy of the table contents and the iterator.
  logic signed [IST_KEY_W-1:0] held_keys [IST_CAPACITY];
  int unsigned                 held_count;
  int unsigned                 iter_pos;
  bit                          iter_live;

  logic signed [IST_KEY_W-1:0] key_pool [POOL_SIZE];
  set_response_t               pending_responses [$];

  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned mismatches;

  sink_mode_e  sink_mode;
  int unsigned sink_mode_left;
  int unsigned sink_stall_left;

  always #2 clk_i = ~clk_i;

  function automatic set_response_t predict_response(input logic [IST_OP_W-1:0] op,
                                                     input logic signed [IST_KEY_W-1:0] key);
    set_response_t resp;
    int unsigned   pos;
    bit            found;
    resp.status = ST_OK;
    resp.item   = '0;
    found       = 1'b0;
    pos         = 0;
    for (int unsigned i = 0; i < held_count; i++) begin
      if (!found && held_keys[i] == key) begin
        found = 1'b1;
        pos   = i;
      end
    end
    case (op)
      OP_INSERT: begin
        if (!found) begin
          if (held_count >= IST_CAPACITY) begin
            resp.status = ST_FULL;
          end else begin
            held_keys[held_count] = key;
            held_count++;
          end
        end
      end
      OP_QUERY: begin
        if (!found) resp.status = ST_NOT_FOUND;
      end
      OP_REMOVE: begin
        if (!found) begin
          resp.status = ST_NOT_FOUND;
        end else begin
          // The last entry fills the hole; the iterator position is left alone.
          held_keys[pos] = held_keys[held_count-1];
          held_count--;
        end
      end
      OP_BEGIN: begin
        iter_pos  = 0;
        iter_live = 1'b1;
      end
      OP_TAKE: begin
        if (!iter_live || iter_pos >= held_count) begin
          resp.status = ST_END;
        end else begin
          resp.item = held_keys[iter_pos];
          iter_pos++;
        end
      end
      default: ;
    endcase
    resp.count = held_count[IST_COUNT_W-1:0];
    return resp;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < REPORT_LIMIT) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  // Sends one request, first idling for a random gap, which may be empty, whenever a burst has run out.
  task automatic send_request(input logic [IST_OP_W-1:0] op,
                              input logic signed [IST_KEY_W-1:0] key);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      repeat (gap) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.valid  <= 1'b1;
    req_if.opcode <= op;
    req_if.key    <= key;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pending_responses.push_back(predict_response(op, key));
    items_sent++;
  endtask

  function automatic logic signed [IST_KEY_W-1:0] pool_key();
    if ($urandom_range(0, 15) == 0) return $urandom;
    return key_pool[$urandom_range(0, POOL_SIZE-1)];
  endfunction

  function automatic logic signed [IST_KEY_W-1:0] likely_held_key();
    if (held_count > 0 && $urandom_range(0, 9) < 7) return held_keys[$urandom_range(0, held_count-1)];
    return pool_key();
  endfunction

  function automatic void refresh_pool(input int unsigned one_in);
    for (int unsigned i = 0; i < POOL_SIZE; i++) begin
      if ($urandom_range(1, one_in) == 1) begin
        case ($urandom_range(0, 11))
          0:       key_pool[i] = KEY_MIN;
          1:       key_pool[i] = KEY_MAX;
          2:       key_pool[i] = '0;
          3:       key_pool[i] = '1;
          default: key_pool[i] = $urandom;
        endcase
      end
    end
  endfunction

  task automatic test_empty_table();
    send_request(OP_TAKE, $urandom);
    send_request(OP_QUERY, '0);
    send_request(OP_REMOVE, KEY_MIN);
    send_request(OP_BEGIN, $urandom);
    send_request(OP_TAKE, $urandom);
    for (int o = int'(OP_TAKE) + 1; o < 2**IST_OP_W; o++) begin
      send_request(o[IST_OP_W-1:0], $urandom);
    end
  endtask

  task automatic test_key_extremes();
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, '0);
    send_request(OP_INSERT, '1);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_QUERY, KEY_MIN);
    send_request(OP_BEGIN, KEY_MAX);
    repeat (5) send_request(OP_TAKE, KEY_MIN);
    send_request(OP_REMOVE, KEY_MIN);
    send_request(OP_QUERY, KEY_MIN);
    send_request(OP_BEGIN, '0);
    send_request(OP_TAKE, '0);
  endtask

  task automatic test_fill_to_capacity();
    while (held_count < IST_CAPACITY) send_request(OP_INSERT, $urandom);
    send_request(OP_INSERT, $urandom);
    send_request(OP_INSERT, held_keys[IST_CAPACITY-1]);
    send_request(OP_QUERY, held_keys[0]);
    send_request(OP_BEGIN, $urandom);
    repeat (IST_CAPACITY + 1) send_request(OP_TAKE, $urandom);
    while (held_count > 0) begin
      if ($urandom_range(0, 4) == 0) send_request(OP_QUERY, likely_held_key());
      send_request(OP_REMOVE, held_keys[$urandom_range(0, held_count-1)]);
    end
  endtask

  // Each segment picks at random a filling, draining or balanced mix, so the count moves over its range.
  task automatic test_random_mix();
    int unsigned seg_left;
    int unsigned w_ins;
    int unsigned w_rem;
    int unsigned pick;
    int unsigned walk_len;
    seg_left = 0;
    w_ins    = 0;
    w_rem    = 0;
    refresh_pool(1);
    while (items_sent < ITEMS_TARGET) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 160);
        refresh_pool(4);
        case ($urandom_range(0, 2))
          0:       begin w_ins = 60; w_rem = 10; end
          1:       begin w_ins = 15; w_rem = 55; end
          default: begin w_ins = 35; w_rem = 30; end
        endcase
      end
      seg_left--;
      pick = $urandom_range(0, 99);
      if (pick < w_ins) begin
        send_request(OP_INSERT, pool_key());
      end else if (pick < w_ins + w_rem) begin
        send_request(OP_REMOVE, likely_held_key());
      end else if (pick < 90) begin
        send_request(OP_QUERY, likely_held_key());
      end else if (pick < 93) begin
        send_request(OP_BEGIN, $urandom);
      end else if (pick < 97) begin
        send_request(OP_TAKE, $urandom);
      end else if (pick < 98) begin
        // A walk of the table from its start, with the odd removal part way through.
        walk_len = held_count + $urandom_range(0, 2);
        send_request(OP_BEGIN, $urandom);
        repeat (walk_len) begin
          if ($urandom_range(0, 9) == 0) send_request(OP_REMOVE, likely_held_key());
          else send_request(OP_TAKE, $urandom);
        end
      end else if (pick < 99) begin
        send_request(IST_OP_W'($urandom_range(int'(OP_TAKE) + 1, 2**IST_OP_W - 1)), $urandom);
      end else begin
        send_request(OP_INSERT, $urandom);
      end
    end
  endtask

  // The receiver switches between always ready, coin-flip ready and runs of stalls.
  always @(negedge clk_i) begin
    if (sink_mode_left == 0) begin
      sink_mode      = sink_mode_e'($urandom_range(0, 2));
      sink_mode_left = $urandom_range(20, 300);
    end
    sink_mode_left--;
    case (sink_mode)
      SINK_FREE:   rsp_if.ready <= 1'b1;
      SINK_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
      default: begin
        if (sink_stall_left > 0) begin
          sink_stall_left--;
          rsp_if.ready <= 1'b0;
        end else begin
          rsp_if.ready <= 1'b1;
          if ($urandom_range(0, 2) == 0) sink_stall_left = $urandom_range(1, 24);
        end
      end
    endcase
  end

  always @(posedge clk_i) begin
    set_response_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (pending_responses.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
      end else begin
        want = pending_responses.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_if.status, want.status));
        if (rsp_if.item !== want.item)
          report_mismatch($sformatf("item got %0d want %0d", rsp_if.item, want.item));
        if (rsp_if.count !== want.count)
          report_mismatch($sformatf("count got %0d want %0d", rsp_if.count, want.count));
      end
    end
  end

  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.opcode   = OP_INSERT;
    req_if.key      = '0;
    rsp_if.ready    = 1'b0;
    held_count      = 0;
    iter_pos        = 0;
    iter_live       = 1'b0;
    items_sent      = 0;
    burst_left      = 0;
    mismatches      = 0;
    sink_mode       = SINK_FREE;
    sink_mode_left  = 0;
    sink_stall_left = 0;
    refresh_pool(1);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table();
    test_key_extremes();
    test_fill_to_capacity();
    test_random_mix();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (IST_CAPACITY + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d responses outstanding", pending_responses.size());
    $display("status: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/ist_pkg.sv
src/ist_in_if.sv
src/ist_out_if.sv
src/ist_mem.sv
src/ist_ctrl.sv
src/integer_set_table.sv
tb/sv/tb_integer_set_table.sv
